>>> hw/rtl/kmp_pkg.sv
// shared types and constants for the kmp stream pattern finder
// no dependencies; used by kmp_ctrl, kmp_datapath and the top level
`default_nettype none

package kmp_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int COUNT_BITS_DEF  = 32;
	localparam int DATA_W          = 8;
	localparam int OFFSET_W        = 32;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_pre;
		logic walk_step;
		logic finish;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic direct;
		logic need_pre;
		logic walk_stop;
		logic res_now;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/kmp_ctrl.sv
// controller state machine for the kmp stream pattern finder
// depends on kmp_pkg (command and status structs)
`default_nettype none

module kmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  kmp_pkg::dp_stat_t stat,
	output kmp_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRE,
		S_WALK,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.load_pre  = (state_q == S_PRE);
		cmd.walk_step = (state_q == S_WALK) && !stat.walk_stop;
		cmd.finish    = (state_q == S_WALK) && stat.walk_stop;
		cmd.emit      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						if (stat.direct)
							state_q <= stat.res_now ? S_EMIT : S_IDLE;
						else
							state_q <= stat.need_pre ? S_PRE : S_WALK;
					end
				end
				S_PRE: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (stat.walk_stop)
						state_q <= stat.res_now ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (cmd.emit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_pre, cmd.walk_step, cmd.finish, cmd.emit}))
		else $error("more than one datapath command at once");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result loaded but output not valid");

	a_pre_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRE) |=> (state_q == S_WALK))
		else $error("prefix read not followed by chain walk");

endmodule

`default_nettype wire

>>> hw/rtl/kmp_datapath.sv
// datapath: pattern and prefix memories, match state, text counter, result registers
// depends on kmp_pkg; driven by kmp_ctrl through dp_cmd_t
`default_nettype none

module kmp_datapath #(
	parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = kmp_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kmp_pkg::dp_cmd_t              cmd,
	output kmp_pkg::dp_stat_t             stat,
	input  logic                          func,
	input  logic [kmp_pkg::DATA_W-1:0]    data,
	input  logic                          first,
	input  logic                          last,
	output logic [1:0]                    status,
	output logic [kmp_pkg::OFFSET_W-1:0]  offset
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int EXT_W = (COUNT_BITS > kmp_pkg::OFFSET_W) ? COUNT_BITS : kmp_pkg::OFFSET_W;
	localparam logic [LEN_W-1:0]      LEN_MAX = LEN_W'(MAX_PATTERN);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// memories
	logic [kmp_pkg::DATA_W-1:0] pat_mem [MAX_PATTERN];
	logic [LEN_W-1:0]           pre_mem [MAX_PATTERN];
	logic [kmp_pkg::DATA_W-1:0] pat_rd;
	logic [LEN_W-1:0]           pre_rd;
	logic [IDX_W-1:0]           pat_addr, pre_addr, wr_addr;
	logic [kmp_pkg::DATA_W-1:0] wr_pat;
	logic [LEN_W-1:0]           wr_pre;
	logic                       mem_we;

	// architectural state
	logic [LEN_W-1:0]      len_q, m_q;
	logic                  ovf_q, done_q;
	logic [COUNT_BITS-1:0] cnt_q;

	// per-transaction registers
	logic [kmp_pkg::DATA_W-1:0]  byte_q;
	logic                        last_q, is_pat_q;
	logic [LEN_W-1:0]            k_q;
	kmp_pkg::status_t            res_status_q, out_status_q;
	logic [kmp_pkg::OFFSET_W-1:0] res_offset_q, out_offset_q;

	logic                  pat_in, first_pat;
	logic [LEN_W-1:0]      len_e, m_e, start_k, k_d, k_m1, len_m1, k_step, k_inc, k_new;
	logic                  done_e, live_e, pat_eq, walk_stop, hit_a, hit_f;
	logic [COUNT_BITS-1:0] cnt_e;
	logic [EXT_W-1:0]      cnt_x, back_x, moff_x, cnt_nx_x;
	logic                  t_hit, t_done_b, t_last, t_res, t_done_nx;
	logic [COUNT_BITS-1:0] t_cnt, cnt_nx;
	logic [kmp_pkg::OFFSET_W-1:0] t_off;
	kmp_pkg::status_t      t_status;

	always_comb begin
		pat_in    = !func;
		first_pat = pat_in && first;
		len_e     = first_pat ? '0 : len_q;
		m_e       = first ? '0 : m_q;
		cnt_e     = first ? '0 : cnt_q;
		done_e    = first ? 1'b0 : done_q;
		live_e    = !done_e && !ovf_q;
		start_k   = (m_e >= len_q) ? '0 : m_e;

		// one link of the failure chain per cycle
		pat_eq    = (pat_rd == byte_q);
		walk_stop = (k_q == '0) || pat_eq;
		k_step    = (pre_rd < k_q) ? pre_rd : '0;
		k_inc     = pat_eq ? k_q + LEN_W'(1) : k_q;
		k_new     = (k_inc > len_q) ? '0 : k_inc;

		k_d = k_q;
		if (cmd.accept && !pat_in)
			k_d = start_k;
		else if (cmd.load_pre)
			k_d = pre_rd;
		else if (cmd.walk_step)
			k_d = k_step;

		k_m1     = k_d - LEN_W'(1);
		len_m1   = len_q - LEN_W'(1);
		pat_addr = k_d[IDX_W-1:0];
		pre_addr = (cmd.accept && pat_in) ? len_m1[IDX_W-1:0] : k_m1[IDX_W-1:0];

		// match start offset, clamped at zero when the count is below the pattern length minus one
		cnt_x  = EXT_W'(cnt_q);
		back_x = EXT_W'(len_q) - EXT_W'(1);
		moff_x = (cnt_x >= back_x) ? cnt_x - back_x : '0;

		hit_a = live_e && (len_q == '0);
		hit_f = (k_inc >= len_q);

		if (cmd.accept) begin
			t_hit    = hit_a;
			t_off    = '0;
			t_cnt    = cnt_e;
			t_done_b = done_e || hit_a;
			t_last   = last;
		end else begin
			t_hit    = hit_f;
			t_off    = moff_x[kmp_pkg::OFFSET_W-1:0];
			t_cnt    = cnt_q;
			t_done_b = hit_f;
			t_last   = last_q;
		end
		cnt_nx    = (t_cnt == CNT_MAX) ? t_cnt : t_cnt + COUNT_BITS'(1);
		cnt_nx_x  = EXT_W'(cnt_nx);
		t_res     = t_hit || (t_last && !t_done_b);
		t_done_nx = t_done_b || t_last;
		if (t_hit)
			t_status = kmp_pkg::ST_FOUND;
		else if (ovf_q)
			t_status = kmp_pkg::ST_OVERFLOW;
		else
			t_status = kmp_pkg::ST_NOT_FOUND;

		stat.direct    = pat_in ? ((len_e >= LEN_MAX) || (len_e == '0))
		                        : !(live_e && (len_q != '0));
		stat.need_pre  = pat_in;
		stat.walk_stop = walk_stop;
		stat.res_now   = cmd.accept ? (!pat_in && stat.direct && t_res) : (!is_pat_q && t_res);

		mem_we  = (cmd.accept && pat_in && (len_e == '0)) || (cmd.finish && is_pat_q);
		wr_addr = cmd.accept ? '0 : len_q[IDX_W-1:0];
		wr_pat  = cmd.accept ? data : byte_q;
		wr_pre  = cmd.accept ? '0 : k_new;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pat_mem[wr_addr] <= wr_pat;
			pre_mem[wr_addr] <= wr_pre;
		end
		pat_rd <= pat_mem[pat_addr];
		pre_rd <= pre_mem[pre_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			m_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (cmd.accept) begin
			if (pat_in) begin
				// a new pattern always lands in entry 0, which sets the length to one
				if (first) begin
					ovf_q  <= 1'b0;
					m_q    <= '0;
					cnt_q  <= '0;
					done_q <= 1'b0;
				end
				if (len_e >= LEN_MAX)
					ovf_q <= 1'b1;
				else if (len_e == '0)
					len_q <= LEN_W'(1);
			end else begin
				m_q <= m_e;
				if (stat.direct) begin
					cnt_q  <= cnt_nx;
					done_q <= t_done_nx;
				end else begin
					cnt_q  <= cnt_e;
					done_q <= done_e;
				end
			end
		end else if (cmd.finish) begin
			if (is_pat_q) begin
				len_q <= len_q + LEN_W'(1);
			end else begin
				m_q    <= hit_f ? '0 : k_inc;
				cnt_q  <= cnt_nx;
				done_q <= t_done_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		if (cmd.accept) begin
			byte_q   <= data;
			last_q   <= last;
			is_pat_q <= pat_in;
		end
		if ((cmd.accept || cmd.finish) && stat.res_now) begin
			res_status_q <= t_status;
			res_offset_q <= t_hit ? t_off : cnt_nx_x[kmp_pkg::OFFSET_W-1:0];
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_offset_q <= res_offset_q;
		end
	end

	assign status = out_status_q;
	assign offset = out_offset_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("pattern length beyond store depth");

	a_walk_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |=> (k_q < $past(k_q)))
		else $error("failure chain link did not shorten the match");

	a_match_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_q < len_q) || (m_q == '0))
		else $error("matched length not below pattern length");

endmodule

`default_nettype wire

>>> hw/rtl/kmp_stream_pattern_finder_unit.sv
// Knuth-Morris-Pratt byte search. Pattern bytes (func=0) build the pattern and its failure
// table one entry per byte; text bytes (func=1) advance the match and walk the failure chain
// on a mismatch. One result per text: status found with the match start offset, or not found
// / pattern overflow with the text length, given on the byte with last=1 if no match came
// first. A text byte is accepted and then walks the failure chain (it is done on acceptance
// once the text has its result, or when the pattern is empty or overflowed); a pattern byte
// also reads its prefix entry before its walk (the first pattern byte and dropped overflow
// bytes are done on acceptance). The walk is bound by the registered read of the pattern and
// prefix memories, one link per cycle. A transaction that yields a result passes through an
// emit state to load the output register; the input stays stalled while it is still full.
// depends on kmp_pkg, kmp_ctrl, kmp_datapath
`default_nettype none

module kmp_stream_pattern_finder_unit #(
	parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = kmp_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [kmp_pkg::DATA_W-1:0]    data,
	input  logic                          first,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [kmp_pkg::OFFSET_W-1:0]  offset
);

	kmp_pkg::dp_cmd_t  cmd;
	kmp_pkg::dp_stat_t stat;

	kmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	kmp_datapath #(
		.MAX_PATTERN (MAX_PATTERN),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.func   (func),
		.data   (data),
		.first  (first),
		.last   (last),
		.status (status),
		.offset (offset)
	);

endmodule

`default_nettype wire
